>>> hdl/tts_pkg.sv
// Shared types, codes and reset constants for the TFTP transfer sequencer.
package tts_pkg;

  // Event commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_RECV  = 2'd2;
  localparam logic [1:0] CMD_TIMER = 2'd3;

  // Send outcomes
  localparam logic [1:0] SEND_OK    = 2'd0;
  localparam logic [1:0] SEND_BLOCK = 2'd1;

  // Received packet kinds
  localparam logic [1:0] PKT_ACK   = 2'd0;
  localparam logic [1:0] PKT_DATA  = 2'd1;
  localparam logic [1:0] PKT_ERROR = 2'd2;
  localparam logic [1:0] PKT_BAD   = 2'd3;

  // Result actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_DATA  = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_OACK  = 3'd3;
  localparam logic [2:0] ACT_ERROR = 3'd4;
  localparam logic [2:0] ACT_STORE = 3'd5;

  // Encoded phase values as seen on the result channel
  localparam logic [2:0] PHC_WAIT_ACK   = 3'd0;
  localparam logic [2:0] PHC_WAIT_DATA  = 3'd1;
  localparam logic [2:0] PHC_SEND_ACK   = 3'd2;
  localparam logic [2:0] PHC_SEND_DATA  = 3'd3;
  localparam logic [2:0] PHC_SEND_OACK  = 3'd4;
  localparam logic [2:0] PHC_SEND_ERROR = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_SECS = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] BLOCK_SIZE_RST   = 16'd512;
  localparam logic [7:0]  TIMEOUT_SECS_RST = 8'd2;
  localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd3;

  // Error code used for protocol and file failures
  localparam logic [1:0] ERR_NOT_DEFINED = 2'd0;

  typedef enum logic [5:0] {
    PH_WAIT_ACK   = 6'b000001,
    PH_WAIT_DATA  = 6'b000010,
    PH_SEND_ACK   = 6'b000100,
    PH_SEND_DATA  = 6'b001000,
    PH_SEND_OACK  = 6'b010000,
    PH_SEND_ERROR = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] block_count;
    logic [3:0]  retry_count;
    logic        last_block_seen;
    logic        block_prepared;
    logic        done_flag;
    logic        write_direction;
    logic [1:0]  pending_error;
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_write;
    logic        has_options;
    logic [1:0]  start_error;
    logic [1:0]  send_status;
    logic [15:0] read_len;
    logic        file_failed;
    logic        at_end_of_file;
    logic [1:0]  packet_kind;
    logic [15:0] packet_block;
    logic [15:0] packet_len;
  } event_t;

  typedef struct packed {
    logic [15:0] block_size;
    logic [7:0]  timeout_seconds;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] cur_block;
    logic [1:0]  err_code;
    logic        pending_read;
    logic        timer_start;
    logic [7:0]  timer_seconds;
    logic        finished;
    logic        waiting_receive;
    logic        waiting_send;
    logic [2:0]  phase;
  } result_t;

  // Map the one-hot phase onto its external code
  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    code = PHC_SEND_ERROR;
    case (ph)
      PH_WAIT_ACK:   code = PHC_WAIT_ACK;
      PH_WAIT_DATA:  code = PHC_WAIT_DATA;
      PH_SEND_ACK:   code = PHC_SEND_ACK;
      PH_SEND_DATA:  code = PHC_SEND_DATA;
      PH_SEND_OACK:  code = PHC_SEND_OACK;
      default:       code = PHC_SEND_ERROR;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/tts_step.sv
// Next-state and result logic for one sequencer event.
module tts_step (
  input  tts_pkg::state_t  st,
  input  tts_pkg::event_t  ev,
  input  tts_pkg::cfg_t    cfg,
  output tts_pkg::state_t  st_next,
  output tts_pkg::result_t res
);

  logic [2:0]  action;
  logic        arm;
  logic        sent;
  logic        failed;
  logic [15:0] prev_block;
  tts_pkg::state_t nx;

  assign sent       = (ev.send_status == tts_pkg::SEND_OK);
  assign failed     = ev.send_status[1];
  assign prev_block = st.block_count - 16'd1;

  // Advance the transfer state for this event
  always_comb begin
    nx     = st;
    action = tts_pkg::ACT_NONE;
    arm    = 1'b0;
    if (!st.done_flag) begin
      case (ev.cmd)
        tts_pkg::CMD_START: begin
          nx.write_direction = ev.is_write;
          nx.pending_error   = ev.start_error;
          nx.retry_count     = 4'd0;
          nx.last_block_seen = 1'b0;
          nx.block_prepared  = 1'b0;
          nx.block_count     = 16'd0;
          if (ev.start_error != tts_pkg::ERR_NOT_DEFINED) begin
            nx.phase = tts_pkg::PH_SEND_ERROR;
          end else if (ev.has_options) begin
            nx.phase = tts_pkg::PH_SEND_OACK;
          end else if (ev.is_write) begin
            nx.phase = tts_pkg::PH_SEND_ACK;
          end else begin
            nx.phase       = tts_pkg::PH_SEND_DATA;
            nx.block_count = 16'd1;
          end
        end
        tts_pkg::CMD_SEND: begin
          unique case (st.phase)
            tts_pkg::PH_SEND_DATA: begin
              if (!st.block_prepared && ev.file_failed) begin
                nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                nx.phase         = tts_pkg::PH_SEND_ERROR;
              end else begin
                // Fetch a fresh block; a short one is the last
                if (!st.block_prepared) begin
                  nx.block_prepared = 1'b1;
                  if (ev.read_len < cfg.block_size) begin
                    nx.last_block_seen = 1'b1;
                  end
                end
                if (sent) begin
                  action   = tts_pkg::ACT_DATA;
                  nx.phase = tts_pkg::PH_WAIT_ACK;
                  arm      = 1'b1;
                end else if (failed) begin
                  nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                  nx.phase         = tts_pkg::PH_SEND_ERROR;
                end
              end
            end
            tts_pkg::PH_SEND_ACK: begin
              if (sent) begin
                action = tts_pkg::ACT_ACK;
                if (st.last_block_seen) begin
                  nx.done_flag = 1'b1;
                end else begin
                  nx.block_count = st.block_count + 16'd1;
                  nx.phase       = tts_pkg::PH_WAIT_DATA;
                  arm            = 1'b1;
                end
              end else if (failed) begin
                nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                nx.phase         = tts_pkg::PH_SEND_ERROR;
              end
            end
            tts_pkg::PH_SEND_OACK: begin
              if (sent) begin
                action = tts_pkg::ACT_OACK;
                arm    = 1'b1;
                if (st.write_direction) begin
                  nx.block_count = 16'd1;
                  nx.phase       = tts_pkg::PH_WAIT_DATA;
                end else begin
                  nx.phase = tts_pkg::PH_WAIT_ACK;
                end
              end else if (failed) begin
                nx.done_flag = 1'b1;
              end
            end
            tts_pkg::PH_SEND_ERROR: begin
              if (sent) begin
                action       = tts_pkg::ACT_ERROR;
                nx.done_flag = 1'b1;
              end else if (failed) begin
                nx.done_flag = 1'b1;
              end
            end
            default: begin
              // Wait phases ignore send outcomes
            end
          endcase
        end
        tts_pkg::CMD_RECV: begin
          unique case (st.phase)
            tts_pkg::PH_WAIT_ACK: begin
              if (ev.packet_kind == tts_pkg::PKT_ACK) begin
                nx.retry_count = 4'd0;
                if (ev.packet_block == prev_block) begin
                  nx.phase = tts_pkg::PH_SEND_DATA;
                end else if (ev.packet_block == st.block_count) begin
                  if (st.last_block_seen) begin
                    nx.done_flag = 1'b1;
                  end else begin
                    nx.block_prepared = 1'b0;
                    nx.phase          = tts_pkg::PH_SEND_DATA;
                    nx.block_count    = st.block_count + 16'd1;
                  end
                end else begin
                  nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                  nx.phase         = tts_pkg::PH_SEND_ERROR;
                end
              end else if (ev.packet_kind == tts_pkg::PKT_ERROR) begin
                nx.done_flag = 1'b1;
              end
            end
            tts_pkg::PH_WAIT_DATA: begin
              if (ev.packet_kind == tts_pkg::PKT_DATA) begin
                nx.retry_count = 4'd0;
                if (ev.packet_block == prev_block) begin
                  nx.block_count = prev_block;
                  nx.phase       = tts_pkg::PH_SEND_ACK;
                end else if (ev.packet_block == st.block_count) begin
                  action = tts_pkg::ACT_STORE;
                  if (ev.file_failed) begin
                    nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                    nx.phase         = tts_pkg::PH_SEND_ERROR;
                  end else begin
                    if (ev.packet_len < cfg.block_size) begin
                      nx.last_block_seen = 1'b1;
                    end
                    nx.phase = tts_pkg::PH_SEND_ACK;
                  end
                end else begin
                  nx.pending_error = tts_pkg::ERR_NOT_DEFINED;
                  nx.phase         = tts_pkg::PH_SEND_ERROR;
                end
              end else if (ev.packet_kind == tts_pkg::PKT_ERROR) begin
                nx.done_flag = 1'b1;
              end
            end
            default: begin
              // Send phases ignore received packets
            end
          endcase
        end
        default: begin
          // Timer expiry: retransmit until the retry budget runs out
          if (st.phase == tts_pkg::PH_WAIT_ACK || st.phase == tts_pkg::PH_WAIT_DATA) begin
            if (st.retry_count >= cfg.retry_limit) begin
              nx.done_flag = 1'b1;
            end else begin
              nx.retry_count = st.retry_count + 4'd1;
              if (st.phase == tts_pkg::PH_WAIT_ACK) begin
                nx.phase = tts_pkg::PH_SEND_DATA;
              end else begin
                nx.phase       = tts_pkg::PH_SEND_ACK;
                nx.block_count = prev_block;
              end
            end
          end
        end
      endcase
    end
  end

  assign st_next = nx;

  // Build the result from the updated state
  always_comb begin
    res.action          = action;
    res.cur_block       = nx.block_count;
    res.err_code        = nx.pending_error;
    res.pending_read    = (nx.phase == tts_pkg::PH_SEND_DATA) && !nx.block_prepared;
    res.timer_start     = arm;
    res.timer_seconds   = (cfg.timeout_seconds == 8'd0) ? 8'd1 : cfg.timeout_seconds;
    res.finished        = nx.done_flag;
    res.waiting_receive = (nx.phase == tts_pkg::PH_WAIT_ACK) ||
                          (nx.phase == tts_pkg::PH_WAIT_DATA);
    res.waiting_send    = !res.waiting_receive;
    res.phase           = tts_pkg::phase_code(nx.phase);
  end

endmodule

>>> hdl/tftp_transfer_sequencer.sv
// Top level of the server-side lockstep TFTP transfer sequencer.
//
// Events enter on the evt channel (evt_valid / evt_stall) and one result per
// event leaves on the res channel (res_valid / res_stall). A transfer happens
// on a clock edge with valid high and stall low.
// The event is captured in an input register; the next-state logic then
// updates the transfer state and the result register from it. One event is
// accepted every cycle while results are taken; the state loop closes
// through the combinational next-state logic alone.
// When the receiver stalls, the held result stays put, the input register
// keeps one more event, and evt_stall rises only once both are full.
// Write configuration registers through cfg_we / cfg_index / cfg_data while
// the block is idle; the block itself leaves this to the user. An index past
// the last register is ignored. Synchronous reset empties both registers,
// restores the configuration defaults and puts the transfer in the
// send-error phase with no block. Once a transfer has finished, every later
// event leaves the state unchanged and reports no action until reset.
module tftp_transfer_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event channel
  input  logic        evt_valid,
  output logic        evt_stall,
  input  logic [1:0]  cmd,
  input  logic        is_write,
  input  logic        has_options,
  input  logic [1:0]  start_error,
  input  logic [1:0]  send_status,
  input  logic [15:0] read_len,
  input  logic        file_failed,
  input  logic        at_end_of_file,
  input  logic [1:0]  packet_kind,
  input  logic [15:0] packet_block,
  input  logic [15:0] packet_len,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  action,
  output logic [15:0] cur_block,
  output logic [1:0]  err_code,
  output logic        pending_read,
  output logic        timer_start,
  output logic [7:0]  timer_seconds,
  output logic        finished,
  output logic        waiting_receive,
  output logic        waiting_send,
  output logic [2:0]  phase
);

  tts_pkg::cfg_t    cfg;
  tts_pkg::state_t  st;
  tts_pkg::state_t  st_next;
  tts_pkg::event_t  evt_q;
  tts_pkg::result_t res_next;
  tts_pkg::result_t res_q;
  logic             evt_q_valid;
  logic             advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size      <= tts_pkg::BLOCK_SIZE_RST;
      cfg.timeout_seconds <= tts_pkg::TIMEOUT_SECS_RST;
      cfg.retry_limit     <= tts_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tts_pkg::REG_BLOCK_SIZE:   cfg.block_size      <= cfg_data;
        tts_pkg::REG_TIMEOUT_SECS: cfg.timeout_seconds <= cfg_data[7:0];
        tts_pkg::REG_RETRY_LIMIT:  cfg.retry_limit     <= cfg_data[3:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // Result register can take a new value when empty or being drained
  assign advance   = !res_valid || !res_stall;
  assign evt_stall = evt_q_valid && !advance;

  // Capture the event
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid <= 1'b0;
    end else if (!evt_stall) begin
      evt_q_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_q <= '{cmd: cmd, is_write: is_write, has_options: has_options,
                 start_error: start_error, send_status: send_status,
                 read_len: read_len, file_failed: file_failed,
                 at_end_of_file: at_end_of_file, packet_kind: packet_kind,
                 packet_block: packet_block, packet_len: packet_len};
    end
  end

  tts_step u_step (
    .st      (st),
    .ev      (evt_q),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res_next)
  );

  // Commit state and result together when the event moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= tts_pkg::PH_SEND_ERROR;
      st.block_count     <= 16'd0;
      st.retry_count     <= 4'd0;
      st.last_block_seen <= 1'b0;
      st.block_prepared  <= 1'b0;
      st.done_flag       <= 1'b0;
      st.write_direction <= 1'b0;
      st.pending_error   <= tts_pkg::ERR_NOT_DEFINED;
      res_valid          <= 1'b0;
    end else if (advance) begin
      res_valid <= evt_q_valid;
      if (evt_q_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt_q_valid) begin
      res_q <= res_next;
    end
  end

  // Drive the result fields
  assign action          = res_q.action;
  assign cur_block       = res_q.cur_block;
  assign err_code        = res_q.err_code;
  assign pending_read    = res_q.pending_read;
  assign timer_start     = res_q.timer_start;
  assign timer_seconds   = res_q.timer_seconds;
  assign finished        = res_q.finished;
  assign waiting_receive = res_q.waiting_receive;
  assign waiting_send    = res_q.waiting_send;
  assign phase           = res_q.phase;

endmodule

>>> hdl/tts_checker.sv
// Port-level checks for the TFTP transfer sequencer, bound to the top level.
module tts_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [2:0]  action,
  input logic [15:0] cur_block,
  input logic        timer_start,
  input logic        finished,
  input logic        waiting_receive,
  input logic        waiting_send,
  input logic [2:0]  phase
);

  logic seen_finished;

  // Remember that a finished result has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_finished <= 1'b0;
    end else if (res_valid && !res_stall && finished) begin
      seen_finished <= 1'b1;
    end
  end

  // A finished transfer stays finished until reset
  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && seen_finished |-> finished)
    else $error("finished dropped after transfer end");

  // Timer arms only on entry to a wait phase
  a_arm_waits: assert property (@(posedge clk) disable iff (rst)
    res_valid && timer_start |-> waiting_receive && !finished)
    else $error("timer armed outside a wait phase");

  // Exactly one of waiting_receive and waiting_send
  a_wait_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> waiting_receive != waiting_send)
    else $error("wait flags inconsistent");

  // A stored payload leaves the block acking or in error
  a_store_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == tts_pkg::ACT_STORE |->
      phase == tts_pkg::PHC_SEND_ACK || phase == tts_pkg::PHC_SEND_ERROR)
    else $error("store result in unexpected phase");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(action) &&
      $stable(cur_block) && $stable(phase))
    else $error("stalled result changed");

endmodule

bind tftp_transfer_sequencer tts_checker u_tts_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the TFTP transfer sequencer: queued events, live prediction, paced channels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed
  localparam logic [1:0] START_OK    = 2'd0;
  localparam logic [1:0] ERR_ACCESS  = 2'd1;
  localparam logic [1:0] ERR_ILLEGAL = 2'd3;
  localparam logic [1:0] SEND_FAIL   = 2'd2;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  localparam int unsigned LEN_MAX      = 65464;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          PHASE_ITEMS  = 160;
  localparam int          FINISH_TRIES = 300;
  localparam int          CYCLE_LIMIT  = 400000;

  // Transfer state as the bench tracks it, phase held as its external code
  typedef struct packed {
    logic [2:0]  ph;
    logic [15:0] blk;
    logic [3:0]  retries;
    logic        last_seen;
    logic        prepared;
    logic        done;
    logic        wr;
    logic [1:0]  err;
  } xfer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        evt_valid = 1'b0;
  tts_pkg::event_t evt_drv = '0;
  logic        res_stall = 1'b0;

  logic        evt_stall;
  logic        res_valid;
  logic [2:0]  action;
  logic [15:0] cur_block;
  logic [1:0]  err_code;
  logic        pending_read;
  logic        timer_start;
  logic [7:0]  timer_seconds;
  logic        finished;
  logic        waiting_receive;
  logic        waiting_send;
  logic [2:0]  phase;

  tts_pkg::event_t  pending_events[$];
  tts_pkg::result_t expected_results[$];

  tts_pkg::cfg_t cfg_now = '{block_size: tts_pkg::BLOCK_SIZE_RST,
                             timeout_seconds: tts_pkg::TIMEOUT_SECS_RST,
                             retry_limit: tts_pkg::RETRY_LIMIT_RST};
  xfer_t plan;
  xfer_t live;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int  hold_left = 0;
  logic accepted_last = 1'b0;

  int mismatches = 0;
  int events_in = 0;
  int starts_seen = 0;
  int results_checked = 0;
  int blocks_sent = 0;
  int payloads_stored = 0;
  int cycle_count = 0;

  tftp_transfer_sequencer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .evt_valid       (evt_valid),
    .evt_stall       (evt_stall),
    .cmd             (evt_drv.cmd),
    .is_write        (evt_drv.is_write),
    .has_options     (evt_drv.has_options),
    .start_error     (evt_drv.start_error),
    .send_status     (evt_drv.send_status),
    .read_len        (evt_drv.read_len),
    .file_failed     (evt_drv.file_failed),
    .at_end_of_file  (evt_drv.at_end_of_file),
    .packet_kind     (evt_drv.packet_kind),
    .packet_block    (evt_drv.packet_block),
    .packet_len      (evt_drv.packet_len),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .action          (action),
    .cur_block       (cur_block),
    .err_code        (err_code),
    .pending_read    (pending_read),
    .timer_start     (timer_start),
    .timer_seconds   (timer_seconds),
    .finished        (finished),
    .waiting_receive (waiting_receive),
    .waiting_send    (waiting_send),
    .phase           (phase)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Transfer predictor
  // ---------------------------------------------------------------------------

  function automatic xfer_t idle_transfer();
    xfer_t s;
    s = '0;
    s.ph = tts_pkg::PHC_SEND_ERROR;
    return s;
  endfunction

  // Drop to the error phase with the generic code
  function automatic void to_error(inout xfer_t s);
    s.err = tts_pkg::ERR_NOT_DEFINED;
    s.ph = tts_pkg::PHC_SEND_ERROR;
  endfunction

  // Advance the transfer by one event and return the result it reports
  function automatic tts_pkg::result_t step_transfer(inout xfer_t s, input tts_pkg::cfg_t c,
                                                     input tts_pkg::event_t e);
    tts_pkg::result_t r;
    logic [15:0] prev;
    logic sent;
    logic failed;
    r = '0;
    r.action = tts_pkg::ACT_NONE;
    prev = s.blk - 16'd1;
    sent = (e.send_status == tts_pkg::SEND_OK);
    failed = (e.send_status > tts_pkg::SEND_BLOCK);
    if (!s.done) begin
      case (e.cmd)
        tts_pkg::CMD_START: begin
          s.wr = e.is_write;
          s.err = e.start_error;
          s.retries = '0;
          s.last_seen = 1'b0;
          s.prepared = 1'b0;
          s.blk = '0;
          if (e.start_error != START_OK) begin
            s.ph = tts_pkg::PHC_SEND_ERROR;
          end else if (e.has_options) begin
            s.ph = tts_pkg::PHC_SEND_OACK;
          end else if (e.is_write) begin
            s.ph = tts_pkg::PHC_SEND_ACK;
          end else begin
            s.ph = tts_pkg::PHC_SEND_DATA;
            s.blk = 16'd1;
          end
        end
        tts_pkg::CMD_SEND: begin
          case (s.ph)
            tts_pkg::PHC_SEND_DATA: begin
              if (!s.prepared && e.file_failed) begin
                to_error(s);
              end else begin
                // Fetch a fresh block; a short one marks the end of file
                if (!s.prepared) begin
                  if (e.read_len < c.block_size) s.last_seen = 1'b1;
                  s.prepared = 1'b1;
                end
                if (sent) begin
                  r.action = tts_pkg::ACT_DATA;
                  r.timer_start = 1'b1;
                  s.ph = tts_pkg::PHC_WAIT_ACK;
                end else if (failed) begin
                  to_error(s);
                end
              end
            end
            tts_pkg::PHC_SEND_ACK: begin
              if (sent) begin
                r.action = tts_pkg::ACT_ACK;
                if (s.last_seen) begin
                  s.done = 1'b1;
                end else begin
                  s.blk = s.blk + 16'd1;
                  s.ph = tts_pkg::PHC_WAIT_DATA;
                  r.timer_start = 1'b1;
                end
              end else if (failed) begin
                to_error(s);
              end
            end
            tts_pkg::PHC_SEND_OACK: begin
              if (sent) begin
                r.action = tts_pkg::ACT_OACK;
                r.timer_start = 1'b1;
                if (s.wr) begin
                  s.blk = 16'd1;
                  s.ph = tts_pkg::PHC_WAIT_DATA;
                end else begin
                  s.ph = tts_pkg::PHC_WAIT_ACK;
                end
              end else if (failed) begin
                s.done = 1'b1;
              end
            end
            tts_pkg::PHC_SEND_ERROR: begin
              if (sent) r.action = tts_pkg::ACT_ERROR;
              if (sent || failed) s.done = 1'b1;
            end
            default: ;
          endcase
        end
        tts_pkg::CMD_RECV: begin
          if (s.ph == tts_pkg::PHC_WAIT_ACK) begin
            if (e.packet_kind == tts_pkg::PKT_ACK) begin
              s.retries = '0;
              if (e.packet_block == prev) begin
                s.ph = tts_pkg::PHC_SEND_DATA;
              end else if (e.packet_block == s.blk) begin
                if (s.last_seen) begin
                  s.done = 1'b1;
                end else begin
                  s.prepared = 1'b0;
                  s.ph = tts_pkg::PHC_SEND_DATA;
                  s.blk = s.blk + 16'd1;
                end
              end else begin
                to_error(s);
              end
            end else if (e.packet_kind == tts_pkg::PKT_ERROR) begin
              s.done = 1'b1;
            end
          end else if (s.ph == tts_pkg::PHC_WAIT_DATA) begin
            if (e.packet_kind == tts_pkg::PKT_DATA) begin
              s.retries = '0;
              if (e.packet_block == prev) begin
                s.blk = prev;
                s.ph = tts_pkg::PHC_SEND_ACK;
              end else if (e.packet_block == s.blk) begin
                r.action = tts_pkg::ACT_STORE;
                if (e.file_failed) begin
                  to_error(s);
                end else begin
                  if (e.packet_len < c.block_size) s.last_seen = 1'b1;
                  s.ph = tts_pkg::PHC_SEND_ACK;
                end
              end else begin
                to_error(s);
              end
            end else if (e.packet_kind == tts_pkg::PKT_ERROR) begin
              s.done = 1'b1;
            end
          end
        end
        default: begin
          // Timer expiry: retransmit until the retry budget runs out
          if (s.ph == tts_pkg::PHC_WAIT_ACK || s.ph == tts_pkg::PHC_WAIT_DATA) begin
            if (s.retries >= c.retry_limit) begin
              s.done = 1'b1;
            end else begin
              s.retries = s.retries + 4'd1;
              if (s.ph == tts_pkg::PHC_WAIT_ACK) begin
                s.ph = tts_pkg::PHC_SEND_DATA;
              end else begin
                s.ph = tts_pkg::PHC_SEND_ACK;
                s.blk = s.blk - 16'd1;
              end
            end
          end
        end
      endcase
    end
    r.cur_block = s.blk;
    r.err_code = s.err;
    r.pending_read = (s.ph == tts_pkg::PHC_SEND_DATA) && !s.prepared;
    r.timer_seconds = (c.timeout_seconds == 8'd0) ? 8'd1 : c.timeout_seconds;
    r.finished = s.done;
    r.waiting_receive = (s.ph == tts_pkg::PHC_WAIT_ACK) || (s.ph == tts_pkg::PHC_WAIT_DATA);
    r.waiting_send = (s.ph >= tts_pkg::PHC_SEND_ACK) && (s.ph <= tts_pkg::PHC_SEND_ERROR);
    r.phase = s.ph;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus shaping
  // ---------------------------------------------------------------------------

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Pick a block length that is either short (ends the file) or full
  function automatic logic [15:0] block_len(input logic [15:0] bs, input logic short_one);
    if (short_one) return 16'($urandom_range(0, int'(bs) - 1));
    return 16'($urandom_range(int'(bs), LEN_MAX));
  endfunction

  function automatic logic [1:0] pick_status();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return tts_pkg::SEND_OK;
    if (roll < 90) return tts_pkg::SEND_BLOCK;
    return SEND_FAIL;
  endfunction

  // Build one event with all fields set
  function automatic tts_pkg::event_t ev(input logic [1:0] op, input int a, input int b,
                                         input int c, input logic ff);
    tts_pkg::event_t e;
    e = '0;
    e.cmd = op;
    e.file_failed = ff;
    e.at_end_of_file = 1'($urandom);
    case (op)
      tts_pkg::CMD_START: begin
        e.is_write = a[0];
        e.has_options = b[0];
        e.start_error = c[1:0];
      end
      tts_pkg::CMD_SEND: begin
        e.send_status = a[1:0];
        e.read_len = b[15:0];
      end
      tts_pkg::CMD_RECV: begin
        e.packet_kind = a[1:0];
        e.packet_block = b[15:0];
        e.packet_len = c[15:0];
      end
      default: ;
    endcase
    return e;
  endfunction

  // Mostly the event that moves the transfer along, with random content
  function automatic tts_pkg::event_t shape_event(input xfer_t s, input logic finishing);
    tts_pkg::event_t e;
    int roll;
    int pick;
    logic [15:0] bs;
    bs = cfg_now.block_size;
    roll = $urandom_range(0, 99);
    e.cmd = 2'($urandom_range(0, 3));
    e.is_write = 1'($urandom);
    e.has_options = 1'($urandom);
    e.start_error = 2'($urandom_range(0, 3));
    e.send_status = 2'($urandom_range(0, 2));
    e.read_len = 16'($urandom_range(0, LEN_MAX));
    e.file_failed = 1'($urandom);
    e.at_end_of_file = 1'($urandom);
    e.packet_kind = 2'($urandom_range(0, 3));
    e.packet_block = 16'($urandom);
    e.packet_len = 16'($urandom_range(0, LEN_MAX));
    if (roll < 8) return e;
    e.start_error = chance(10) ? 2'($urandom_range(1, 3)) : START_OK;
    if (roll < 11 || (s.ph == tts_pkg::PHC_SEND_ERROR && !finishing)) begin
      e.cmd = tts_pkg::CMD_START;
      return e;
    end
    e.file_failed = chance(5);
    case (s.ph)
      tts_pkg::PHC_WAIT_ACK, tts_pkg::PHC_WAIT_DATA: begin
        if (chance(12)) begin
          e.cmd = tts_pkg::CMD_TIMER;
        end else begin
          e.cmd = tts_pkg::CMD_RECV;
          e.packet_kind = (s.ph == tts_pkg::PHC_WAIT_ACK) ? tts_pkg::PKT_ACK : tts_pkg::PKT_DATA;
          e.packet_len = block_len(bs, chance(10));
          pick = $urandom_range(0, 99);
          if (pick < 75) e.packet_block = s.blk;
          else if (pick < 88) e.packet_block = s.blk - 16'd1;
        end
      end
      default: begin
        e.cmd = tts_pkg::CMD_SEND;
        e.send_status = pick_status();
        e.read_len = block_len(bs, chance(10));
      end
    endcase
    return e;
  endfunction

  // Queue an event; outside the closing phase, swap an ending one for a restart
  task automatic queue_event(input tts_pkg::event_t e, input logic finishing);
    xfer_t trial;
    tts_pkg::result_t r;
    trial = plan;
    r = step_transfer(trial, cfg_now, e);
    if (r.finished && !finishing && !plan.done) begin
      e.cmd = tts_pkg::CMD_START;
      e.start_error = START_OK;
      trial = plan;
      r = step_transfer(trial, cfg_now, e);
    end
    plan = trial;
    pending_events.insert(pending_events.size(), e);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tts_pkg::REG_BLOCK_SIZE:   cfg_now.block_size = val;
      tts_pkg::REG_TIMEOUT_SECS: cfg_now.timeout_seconds = val[7:0];
      tts_pkg::REG_RETRY_LIMIT:  cfg_now.retry_limit = val[3:0];
      default: ;
    endcase
  endtask

  // Wait until every queued event has been taken and every result checked
  task automatic settle();
    do @(posedge clk);
    while (pending_events.size() != 0 || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int bs, input int tmo,
                           input int retries, input logic hold);
    write_reg(tts_pkg::REG_BLOCK_SIZE, 16'(bs));
    write_reg(tts_pkg::REG_TIMEOUT_SECS, 16'(tmo));
    write_reg(tts_pkg::REG_RETRY_LIMIT, 16'(retries));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) queue_event(shape_event(plan, 1'b0), 1'b0);
    hold_request = hold;
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Event driver
  // ---------------------------------------------------------------------------

  // Offer the next event once the current one is taken, or idle
  always @(negedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || accepted_last) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        evt_valid <= 1'b1;
        evt_drv <= pending_events[0];
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Stall results at random; hold off once for a long stretch when asked
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        res_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then predict for each event transfer
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tts_pkg::result_t got;
    tts_pkg::result_t want;
    tts_pkg::result_t next_want;
    if (rst) begin
      accepted_last <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got = {action, cur_block, err_code, pending_read, timer_start, timer_seconds,
               finished, waiting_receive, waiting_send, phase};
        if (expected_results.size() == 0) begin
          $error("result with no event outstanding: action %0d, block %0d",
                 got.action, got.cur_block);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("action", 16'(want.action), 16'(got.action));
          check_field("cur_block", want.cur_block, got.cur_block);
          check_field("err_code", 16'(want.err_code), 16'(got.err_code));
          check_field("pending_read", 16'(want.pending_read), 16'(got.pending_read));
          check_field("timer_start", 16'(want.timer_start), 16'(got.timer_start));
          check_field("timer_seconds", 16'(want.timer_seconds), 16'(got.timer_seconds));
          check_field("finished", 16'(want.finished), 16'(got.finished));
          check_field("waiting_receive", 16'(want.waiting_receive),
                      16'(got.waiting_receive));
          check_field("waiting_send", 16'(want.waiting_send), 16'(got.waiting_send));
          check_field("phase", 16'(want.phase), 16'(got.phase));
          results_checked++;
          if (got.action == tts_pkg::ACT_DATA) blocks_sent++;
          if (got.action == tts_pkg::ACT_STORE) payloads_stored++;
        end
      end
      if (evt_valid && !evt_stall) begin
        void'(pending_events.pop_front());
        next_want = step_transfer(live, cfg_now, evt_drv);
        expected_results.insert(expected_results.size(), next_want);
        events_in++;
        if (evt_drv.cmd == tts_pkg::CMD_START) starts_seen++;
      end
      accepted_last <= evt_valid && !evt_stall;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int n;
    plan = idle_transfer();
    live = idle_transfer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle error phase, start variants, read and write paths, wraps
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_BLOCK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_TIMER, 0, 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 0, 0, int'(ERR_ACCESS), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 1, 1, int'(ERR_ILLEGAL), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 0, 0, int'(START_OK), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b1), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 0, 1, int'(START_OK), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_ACK), 65535, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), LEN_MAX, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_TIMER, 0, 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_BAD), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_ACK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 512, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_ACK), 7, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 1, 1, int'(START_OK), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_TIMER, 0, 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_DATA), 0, 512, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(SEND_FAIL), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_START, 1, 0, int'(START_OK), 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_SEND, int'(tts_pkg::SEND_OK), 0, 0, 1'b0), 1'b0);
    queue_event(ev(tts_pkg::CMD_RECV, int'(tts_pkg::PKT_DATA), 1, 512, 1'b1), 1'b0);
    settle();

    // Random phases, each with its own pacing and register setting
    write_reg(REG_UNUSED, 16'($urandom));
    run_phase(0, 0, 8, 255, 15, 1'b0);
    run_phase(46, 0, LEN_MAX, 1, 0, 1'b0);
    run_phase(0, 46, $urandom_range(8, LEN_MAX), $urandom_range(1, 255),
              $urandom_range(0, 15), 1'b0);
    run_phase(18, 18, 1024, 7, 2, 1'b0);
    run_phase(0, 18, $urandom_range(8, 2048), $urandom_range(1, 255),
              $urandom_range(1, 15), 1'b1);

    // Let the transfer run to its end, then confirm later events change nothing
    send_idle_pct = 18;
    recv_stall_pct = 18;
    for (n = 0; n < FINISH_TRIES && !plan.done; n++) queue_event(shape_event(plan, 1'b1), 1'b1);
    queue_event(ev(tts_pkg::CMD_START, 1, 1, int'(START_OK), 1'b0), 1'b1);
    repeat (5) queue_event(shape_event(plan, 1'b1), 1'b1);
    settle();

    $display("Checked %0d results for %0d events across %0d starts: %0d blocks sent, %0d stored;",
             results_checked, events_in, starts_seen, blocks_sent, payloads_stored);
    $display("pacing ran free, gapped, stalled and held off; transfer %s at the end.",
             live.done ? "finished" : "still open");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
